/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, codes and the command record passed from the front end to
// the back end through the command queue.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = ROWS * COLS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int IDX_W  = 11;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int CELL_W = 16;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

   typedef enum logic [1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic {
      BK_RUN  = 1'b0,
      BK_FILL = 1'b1
   } bk_state_type;

   typedef struct packed {
      logic              do_write;
      logic              do_read;
      logic              fill_row;
      logic              fill_all;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] fill_addr;
      logic [7:0]        char_code;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* hw/rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// Text console writer front end
// Decodes requests, keeps the cursor and the scroll base, and turns each
// request into one command record with physical cell addresses.
// ----------------------------------------------------------------------------
module tcw_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     req_type,
   input  logic [7:0]                     req_char_code,
   input  logic [tcw_pkg::IDX_W-1:0]      req_cell_index,
   output tcw_pkg::entry_type             entry
);

   logic [tcw_pkg::ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [tcw_pkg::COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [tcw_pkg::ADDR_W-1:0] base_off_ff, base_off_in;

   logic                       newline;
   logic                       wrap;
   logic                       scroll;
   logic [tcw_pkg::COL_W-1:0]  col_inc;
   logic [tcw_pkg::ROW_W-1:0]  row_inc;
   logic [tcw_pkg::SUM_W-1:0]  lin_addr;
   logic [tcw_pkg::SUM_W-1:0]  src_addr;
   logic [tcw_pkg::SUM_W-1:0]  phys_sum;
   logic [tcw_pkg::ADDR_W-1:0] phys_addr;
   logic [tcw_pkg::SUM_W-1:0]  base_sum;
   logic [tcw_pkg::ADDR_W-1:0] base_adv;
   tcw_pkg::req_code_type      code;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         base_off_ff <= '0;
      end else if (accept) begin
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         base_off_ff <= base_off_in;
      end
   end

   always_comb begin
      code     = tcw_pkg::req_code_type'(req_type);
      newline  = (req_char_code == tcw_pkg::NEWLINE_CODE);
      col_inc  = cur_col_ff + tcw_pkg::COL_W'(1);
      row_inc  = cur_row_ff + tcw_pkg::ROW_W'(1);
      wrap     = newline || (col_inc == tcw_pkg::COL_W'(tcw_pkg::COLS));
      scroll   = wrap && (row_inc == tcw_pkg::ROW_W'(tcw_pkg::ROWS));

      lin_addr = tcw_pkg::SUM_W'(cur_row_ff) * tcw_pkg::SUM_W'(tcw_pkg::COLS)
               + tcw_pkg::SUM_W'(cur_col_ff);
      src_addr = (code == tcw_pkg::REQ_PUT) ? lin_addr : tcw_pkg::SUM_W'(req_cell_index);
      phys_sum = src_addr + tcw_pkg::SUM_W'(base_off_ff);
      if (phys_sum >= tcw_pkg::SUM_W'(tcw_pkg::CELLS)) begin
         phys_addr = tcw_pkg::ADDR_W'(phys_sum - tcw_pkg::SUM_W'(tcw_pkg::CELLS));
      end else begin
         phys_addr = tcw_pkg::ADDR_W'(phys_sum);
      end

      base_sum = tcw_pkg::SUM_W'(base_off_ff) + tcw_pkg::SUM_W'(tcw_pkg::COLS);
      if (base_sum >= tcw_pkg::SUM_W'(tcw_pkg::CELLS)) begin
         base_adv = '0;
      end else begin
         base_adv = tcw_pkg::ADDR_W'(base_sum);
      end

      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      base_off_in = base_off_ff;

      entry           = '0;
      entry.addr      = phys_addr;
      entry.fill_addr = base_off_ff;
      entry.char_code = req_char_code;

      unique case (code)
         tcw_pkg::REQ_PUT: begin
            entry.do_write = !newline;
            entry.fill_row = scroll;
            if (wrap) begin
               cur_col_in = '0;
               cur_row_in = scroll ? cur_row_ff : row_inc;
            end else begin
               cur_col_in = col_inc;
            end
            if (scroll) begin
               base_off_in = base_adv;
            end
         end
         tcw_pkg::REQ_CLEAR: begin
            entry.fill_all = 1'b1;
            cur_row_in     = '0;
            cur_col_in     = '0;
            base_off_in    = '0;
         end
         tcw_pkg::REQ_READ: begin
            entry.do_read = (req_cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELLS));
         end
         tcw_pkg::REQ_NONE: begin
         end
      endcase

      entry.row = cur_row_in;
      entry.col = cur_col_in;
   end

endmodule

/* hw/rtl/tcw_queue.sv */
// ----------------------------------------------------------------------------
// Text console writer command queue
// A short first-in first-out queue of command records between front and back.
// ----------------------------------------------------------------------------
module tcw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tcw_pkg::entry_type    push_entry,
   input  logic                  pop,
   output tcw_pkg::entry_type    head,
   output tcw_pkg::q_status_type status
);

   tcw_pkg::entry_type               slots_ff [tcw_pkg::Q_DEPTH];
   logic [tcw_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   always_comb begin
      status.full  = (count_ff == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + tcw_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop  ? rd_ptr_ff + tcw_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + tcw_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tcw_pkg::Q_CNT_W'(1);
      end
      head = slots_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the screen memory and the colour register, carries out queued commands
// and runs the fill sweeps for reset, clear and scroll.
// ----------------------------------------------------------------------------
module tcw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [7:0]                   csr_text_color,
   input  tcw_pkg::entry_type           head,
   input  tcw_pkg::q_status_type        q_status,
   output logic                         pop,
   output logic                         init_busy,
   output logic                         rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]   rsp_cell_data,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col
);

   logic [tcw_pkg::CELL_W-1:0]  cells_mem [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0]  mem_q_ff;

   tcw_pkg::bk_state_type       state_ff, state_in;
   logic [tcw_pkg::ADDR_W-1:0]  fill_addr_ff, fill_addr_in;
   logic [tcw_pkg::CNT_W-1:0]   fill_left_ff, fill_left_in;
   logic                        fill_resp_ff, fill_resp_in;
   logic [7:0]                  text_color_ff;
   logic                        strobe_ff, strobe_in;
   logic                        read_ff, read_in;
   logic [tcw_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]   col_ff, col_in;

   logic                        we;
   logic [tcw_pkg::ADDR_W-1:0]  wa;
   logic [tcw_pkg::CELL_W-1:0]  wd;
   logic                        re;
   logic [tcw_pkg::CELL_W-1:0]  blank;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::BK_FILL;
         fill_addr_ff  <= '0;
         fill_left_ff  <= tcw_pkg::CNT_W'(tcw_pkg::CELLS);
         fill_resp_ff  <= 1'b0;
         text_color_ff <= tcw_pkg::RESET_ATTR;
         strobe_ff     <= 1'b0;
         read_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
         fill_left_ff <= fill_left_in;
         fill_resp_ff <= fill_resp_in;
         strobe_ff    <= strobe_in;
         read_ff      <= read_in;
         if (csr_valid) begin
            text_color_ff <= csr_text_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
   end

   always_comb begin
      blank        = fill_resp_ff ? {text_color_ff, tcw_pkg::SPACE_CODE}
                                  : {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
      state_in     = state_ff;
      fill_addr_in = fill_addr_ff;
      fill_left_in = fill_left_ff;
      fill_resp_in = fill_resp_ff;
      strobe_in    = 1'b0;
      read_in      = 1'b0;
      row_in       = row_ff;
      col_in       = col_ff;
      pop          = 1'b0;
      we           = 1'b0;
      wa           = head.addr;
      wd           = {text_color_ff, head.char_code};
      re           = 1'b0;

      unique case (state_ff)
         tcw_pkg::BK_RUN: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               we     = head.do_write;
               re     = head.do_read;
               row_in = head.row;
               col_in = head.col;
               if (head.fill_row || head.fill_all) begin
                  state_in     = tcw_pkg::BK_FILL;
                  fill_resp_in = 1'b1;
                  fill_addr_in = head.fill_all ? '0 : head.fill_addr;
                  fill_left_in = head.fill_all ? tcw_pkg::CNT_W'(tcw_pkg::CELLS)
                                               : tcw_pkg::CNT_W'(tcw_pkg::COLS);
               end else begin
                  strobe_in = 1'b1;
                  read_in   = head.do_read;
               end
            end
         end
         tcw_pkg::BK_FILL: begin
            we           = 1'b1;
            wa           = fill_addr_ff;
            wd           = blank;
            fill_addr_in = fill_addr_ff + tcw_pkg::ADDR_W'(1);
            fill_left_in = fill_left_ff - tcw_pkg::CNT_W'(1);
            if (fill_left_ff == tcw_pkg::CNT_W'(1)) begin
               state_in  = tcw_pkg::BK_RUN;
               strobe_in = fill_resp_ff;
            end
         end
         default: begin
            state_in = tcw_pkg::BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         cells_mem[wa] <= wd;
      end
      if (re) begin
         mem_q_ff <= cells_mem[head.addr];
      end
   end

   assign init_busy      = (state_ff == tcw_pkg::BK_FILL) && !fill_resp_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_cell_data  = read_ff ? mem_q_ff : '0;
   assign rsp_cursor_row = row_ff;
   assign rsp_cursor_col = col_ff;

endmodule

/* hw/rtl/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// Text console writer
// A text screen of 16-bit cells with a cursor: put, clear and read requests.
//
//   Channel   Ports                                   Transfer rule
//   request   start, busy, req_*                      start high, busy low
//   response  rsp_strobe, rsp_*                       one cycle per beat
//   config    csr_valid, csr_ready, csr_text_color    valid and ready high
//
// Puts without a scroll, newlines without a scroll and reads are issued from
// the command queue back to back; each response is registered for the next cycle.
// A scroll blanks one row and a clear blanks every cell, one cell at a time,
// both through the single write port of the screen memory.
// After reset a clearing pass over every cell runs with busy held high.
// busy also rises while the command queue is full; responses are never held.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_type,
   input  logic [7:0]                   req_char_code,
   input  logic [tcw_pkg::IDX_W-1:0]    req_cell_index,
   output logic                         rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]   rsp_cell_data,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [7:0]                   csr_text_color
);

   tcw_pkg::entry_type    new_entry;
   tcw_pkg::entry_type    head;
   tcw_pkg::q_status_type q_status;
   logic                  accept;
   logic                  pop;
   logic                  init_busy;

   assign busy      = q_status.full || init_busy;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   tcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .entry          (new_entry)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (new_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid && csr_ready),
      .csr_text_color (csr_text_color),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col)
   );

endmodule

/* hw/rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the top-level ports for cursor range, reset behaviour and config readiness.
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   input logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   input logic                         csr_ready
);

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
      else $error("cursor row out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLS)))
      else $error("cursor column out of range");

   a_clear_pass_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("request port open during the clearing pass");

   a_no_beat_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_strobe)
      else $error("response beat straight after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      $past(start) |-> csr_ready)
      else $error("configuration port not ready");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cursor_col (rsp_cursor_col),
   .csr_ready      (csr_ready)
);
